>>> rtl/pdpq_pkg.sv
// Package for the priority-drop packet queue.
// Holds word types, request/status codes and sizing constants.
// No dependencies.
package pdpq_pkg;

   localparam int QUEUE_DEPTH  = 16;
   localparam int LENGTH_BITS  = 16;
   localparam int IDX_W        = $clog2(QUEUE_DEPTH);
   localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
   localparam int ELEN_W       = LENGTH_BITS + 1;
   localparam int BUDGET_FLOOR = 32 * 1024;
   localparam int BACKLOG_FLOOR = 8 * 1024;

   // request codes
   localparam logic [2:0] REQ_PUBLISH = 3'd0;
   localparam logic [2:0] REQ_DRAIN   = 3'd1;
   localparam logic [2:0] REQ_ATTACH  = 3'd2;
   localparam logic [2:0] REQ_DETACH  = 3'd3;
   localparam logic [2:0] REQ_WERR    = 3'd4;
   localparam logic [2:0] REQ_STAT    = 3'd5;

   // status codes
   localparam logic [3:0] ST_ACCEPTED   = 4'd0;
   localparam logic [3:0] ST_INACTIVE   = 4'd1;
   localparam logic [3:0] ST_EMPTY      = 4'd2;
   localparam logic [3:0] ST_NO_ROOM    = 4'd3;
   localparam logic [3:0] ST_SENT_WHOLE = 4'd4;
   localparam logic [3:0] ST_SENT_PART  = 4'd5;
   localparam logic [3:0] ST_NONE_SENT  = 4'd6;
   localparam logic [3:0] ST_STAT       = 4'd7;
   localparam logic [3:0] ST_EVENT_DONE = 4'd8;

   // statistic selectors
   localparam logic [2:0] SEL_PUB       = 3'd0;
   localparam logic [2:0] SEL_PUB_BYTES = 3'd1;

   // event counter slots
   localparam logic [2:0] CNT_PUB      = 3'd0;
   localparam logic [2:0] CNT_SENT     = 3'd1;
   localparam logic [2:0] CNT_DROP_LOW = 3'd2;
   localparam logic [2:0] CNT_WERR     = 3'd5;
   localparam int         NUM_CNT      = 6;

   // register indexes
   localparam logic [1:0] REG_ENABLED = 2'd0;
   localparam logic [1:0] REG_BUDGET  = 2'd1;
   localparam logic [1:0] REG_LIMIT   = 2'd2;

   localparam logic [1:0] PRIO_LOW  = 2'd0;
   localparam logic [1:0] PRIO_MED  = 2'd1;
   localparam logic [1:0] PRIO_HIGH = 2'd2;

   typedef struct packed {
      logic [2:0]             req_type;
      logic [LENGTH_BITS-1:0] pkt_length;
      logic                   has_newline;
      logic [1:0]             prio;
      logic                   may_drop;
      logic [23:0]            sink_backlog;
      logic [15:0]            accept_bytes;
      logic [2:0]             stat_select;
   } pdpq_req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [4:0]  evicted_count;
      logic [16:0] sent_bytes;
      logic        last;
      logic [4:0]  queued_count;
      logic [23:0] held_bytes;
      logic [47:0] stat_value;
      logic        listener_up;
   } pdpq_rsp_type;

   typedef struct packed {
      logic [ELEN_W-1:0] len;
      logic [1:0]        prio;
      logic              drop;
   } pdpq_entry_type;

endpackage

>>> rtl/priority_drop_packet_queue.sv
// Priority-drop packet queue: descriptor FIFO under a byte budget.
// Entry table in one synchronous RAM used as a ring; depends on pdpq_pkg.
// Events, statistic reads and publishes refused at start answer in the cycle after start.
// A fitting publish is written in check; each eviction adds a check, a scan of the queue
// and a pick, plus a read and a write per entry moved down behind the evicted one.
// A drain reads the head entry and then evaluates it for each piece sent, one after another.
// One item at a time: busy stays high until the last word is out; no stall.
// Synchronous reset clears queue, listener, counters; registers take floor values.
module priority_drop_packet_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  pdpq_pkg::pdpq_req_type req_item,
   output logic                  rsp_valid,
   output pdpq_pkg::pdpq_rsp_type rsp_item,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [23:0]           csr_wdata
);
   import pdpq_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_CHECK   = 4'd1;
   localparam logic [3:0] S_SCAN    = 4'd2;
   localparam logic [3:0] S_PICK    = 4'd3;
   localparam logic [3:0] S_SH_RD   = 4'd4;
   localparam logic [3:0] S_SH_WR   = 4'd5;
   localparam logic [3:0] S_DR_RD   = 4'd6;
   localparam logic [3:0] S_DR_EVAL = 4'd7;
   localparam logic [3:0] S_DR_END  = 4'd8;

   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

   pdpq_entry_type mem [QUEUE_DEPTH];
   pdpq_entry_type rdata_ff;
   logic [IDX_W-1:0] raddr, waddr;
   pdpq_entry_type wdata;
   logic mem_we;

   logic [3:0] state_ff, state_in;
   logic [ELEN_W-1:0] len_ff, len_in;
   logic [1:0] prio_ff, prio_in;
   logic drop_ff, drop_in;
   logic [CNT_W-1:0] evict_ff, evict_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [24:0] bytes_ff, bytes_in;
   logic listen_ff, listen_in, en_ff, en_in;
   logic [23:0] budget_ff, budget_in, limit_ff, limit_in;
   logic [31:0] cnt_ff [NUM_CNT];
   logic [31:0] cnt_in [NUM_CNT];
   logic [47:0] pubbytes_ff, pubbytes_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic rdv_ff, rdv_in;
   logic [IDX_W-1:0] rdidx_ff, rdidx_in;
   logic [2:0] found_ff, found_in;
   logic [IDX_W-1:0] fidx_ff [3];
   logic [IDX_W-1:0] fidx_in [3];
   logic [ELEN_W-1:0] flen_ff [3];
   logic [ELEN_W-1:0] flen_in [3];
   logic [24:0] backlog_ff, backlog_in;
   logic [15:0] dbud_ff, dbud_in;
   logic [CNT_W-1:0] nsent_ff, nsent_in;
   pdpq_rsp_type pend_ff, pend_in, rsp_ff, rsp_in;
   logic pendv_ff, pendv_in, rspv_ff, rspv_in;

   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] hd,
                                              input logic [CNT_W-1:0] j);
      logic [IDX_W+CNT_W:0] s;
      s = (IDX_W+CNT_W+1)'(hd) + (IDX_W+CNT_W+1)'(j);
      if (s >= (IDX_W+CNT_W+1)'(QUEUE_DEPTH)) begin
         s = s - (IDX_W+CNT_W+1)'(QUEUE_DEPTH);
      end
      return IDX_W'(s);
   endfunction

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_comb begin
      logic emit_new, emit_pend, pend_last;
      logic [3:0] st;
      logic [47:0] statv;
      logic [16:0] w;
      logic [1:0] q;
      logic qok;
      logic [25:0] need;
      logic [16:0] len1;
      logic [IDX_W:0] hn;
      state_in = state_ff; len_in = len_ff; prio_in = prio_ff; drop_in = drop_ff;
      evict_in = evict_ff; count_in = count_ff; head_in = head_ff; bytes_in = bytes_ff;
      listen_in = listen_ff; en_in = en_ff; budget_in = budget_ff; limit_in = limit_ff;
      cnt_in = cnt_ff; pubbytes_in = pubbytes_ff; j_in = j_ff;
      rdv_in = 1'b0; rdidx_in = rdidx_ff; found_in = found_ff;
      fidx_in = fidx_ff; flen_in = flen_ff; backlog_in = backlog_ff; dbud_in = dbud_ff;
      nsent_in = nsent_ff; pend_in = pend_ff; pendv_in = pendv_ff;
      raddr = head_ff; waddr = head_ff; wdata = rdata_ff; mem_we = 1'b0;
      emit_new = 1'b0; emit_pend = 1'b0; pend_last = 1'b0;
      st = ST_EVENT_DONE; statv = '0; w = '0; q = PRIO_LOW; qok = 1'b0;
      need = '0; hn = '0;
      len1 = {1'b0, req_item.pkt_length} + 17'(!req_item.has_newline);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               prio_in = (req_item.prio == 2'd3) ? PRIO_LOW : req_item.prio;
               drop_in = req_item.may_drop;
               evict_in = '0;
               case (req_item.req_type)
                  REQ_PUBLISH: begin
                     if (!en_ff || !listen_ff) begin
                        emit_new = 1'b1; st = ST_INACTIVE;
                     end else if (req_item.pkt_length == '0) begin
                        emit_new = 1'b1; st = ST_EMPTY;
                     end else begin
                        cnt_in[CNT_PUB] = cnt_ff[CNT_PUB] + 32'd1;
                        pubbytes_in = pubbytes_ff + 48'(len1);
                        len_in = len1;
                        if (req_item.may_drop && 24'(len1) > budget_ff) begin
                           cnt_in[CNT_DROP_LOW + 3'(prio_in)] =
                              cnt_ff[CNT_DROP_LOW + 3'(prio_in)] + 32'd1;
                           emit_new = 1'b1; st = ST_NO_ROOM;
                        end else begin
                           state_in = S_CHECK;
                        end
                     end
                  end
                  REQ_DRAIN: begin
                     if (!en_ff || !listen_ff) begin
                        emit_new = 1'b1; st = ST_INACTIVE;
                     end else if (count_ff == '0) begin
                        emit_new = 1'b1; st = ST_EMPTY;
                     end else begin
                        backlog_in = {1'b0, req_item.sink_backlog};
                        dbud_in = req_item.accept_bytes;
                        nsent_in = '0; pendv_in = 1'b0;
                        state_in = S_DR_RD;
                     end
                  end
                  REQ_ATTACH: begin
                     if (en_ff) begin
                        count_in = '0; bytes_in = '0; listen_in = 1'b1;
                     end
                     emit_new = 1'b1;
                  end
                  REQ_DETACH: begin
                     count_in = '0; bytes_in = '0; listen_in = 1'b0; emit_new = 1'b1;
                  end
                  REQ_WERR: begin
                     if (listen_ff) begin
                        cnt_in[CNT_WERR] = cnt_ff[CNT_WERR] + 32'd1;
                        count_in = '0; bytes_in = '0; listen_in = 1'b0;
                     end
                     emit_new = 1'b1;
                  end
                  REQ_STAT: begin
                     if (req_item.stat_select == SEL_PUB) begin
                        statv = 48'(cnt_ff[CNT_PUB]);
                     end else if (req_item.stat_select == SEL_PUB_BYTES) begin
                        statv = pubbytes_ff;
                     end else if (req_item.stat_select != 3'd7) begin
                        statv = 48'(cnt_ff[req_item.stat_select - 3'd1]);
                     end
                     emit_new = 1'b1; st = ST_STAT;
                  end
                  default: begin
                     emit_new = 1'b1;
                  end
               endcase
            end
         end
         S_CHECK: begin
            need = 26'(bytes_ff) + 26'(len_ff);
            if (need > 26'(budget_ff) || count_ff >= DEPTH_C) begin
               j_in = '0; found_in = '0; state_in = S_SCAN;
            end else begin
               mem_we = 1'b1;
               waddr = phys(head_ff, count_ff);
               wdata = '{len: len_ff, prio: prio_ff, drop: drop_ff};
               count_in = count_ff + 1'b1;
               bytes_in = bytes_ff + 25'(len_ff);
               emit_new = 1'b1; st = ST_ACCEPTED;
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (rdv_ff) begin
               for (int k = 0; k < 3; k++) begin
                  if (rdata_ff.drop && rdata_ff.prio == 2'(k) && !found_ff[k]) begin
                     found_in[k] = 1'b1;
                     fidx_in[k] = rdidx_ff;
                     flen_in[k] = rdata_ff.len;
                  end
               end
            end
            if (j_ff < count_ff) begin
               raddr = phys(head_ff, j_ff);
               rdv_in = 1'b1;
               rdidx_in = IDX_W'(j_ff);
               j_in = j_ff + 1'b1;
            end else if (!rdv_ff) begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            if (found_ff[0]) begin
               q = PRIO_LOW; qok = 1'b1;
            end else if (found_ff[1] && prio_ff >= PRIO_MED) begin
               q = PRIO_MED; qok = 1'b1;
            end else if (found_ff[2] && prio_ff >= PRIO_HIGH) begin
               q = PRIO_HIGH; qok = 1'b1;
            end
            if (!qok) begin
               cnt_in[CNT_DROP_LOW + 3'(prio_ff)] =
                  cnt_ff[CNT_DROP_LOW + 3'(prio_ff)] + 32'd1;
               emit_new = 1'b1; st = ST_NO_ROOM;
               state_in = S_IDLE;
            end else begin
               cnt_in[CNT_DROP_LOW + 3'(q)] = cnt_ff[CNT_DROP_LOW + 3'(q)] + 32'd1;
               evict_in = evict_ff + 1'b1;
               bytes_in = bytes_ff - 25'(flen_ff[q]);
               count_in = count_ff - 1'b1;
               j_in = CNT_W'(fidx_ff[q]);
               // close the gap only when entries sit behind the evicted one
               state_in = (CNT_W'(fidx_ff[q]) < count_in) ? S_SH_RD : S_CHECK;
            end
         end
         S_SH_RD: begin
            raddr = phys(head_ff, j_ff + 1'b1);
            state_in = S_SH_WR;
         end
         S_SH_WR: begin
            mem_we = 1'b1;
            waddr = phys(head_ff, j_ff);
            wdata = rdata_ff;
            j_in = j_ff + 1'b1;
            state_in = (j_in < count_ff) ? S_SH_RD : S_CHECK;
         end
         S_DR_RD: begin
            raddr = head_ff;
            state_in = S_DR_EVAL;
         end
         S_DR_EVAL: begin
            w = (17'(dbud_ff) < rdata_ff.len) ? 17'(dbud_ff) : rdata_ff.len;
            if (backlog_ff > 25'(limit_ff) || w == '0) begin
               if (pendv_ff) begin
                  emit_pend = 1'b1; pend_last = 1'b1;
               end else begin
                  emit_new = 1'b1; st = ST_NONE_SENT;
               end
               state_in = S_IDLE;
            end else begin
               backlog_in = backlog_ff + 25'(w);
               dbud_in = dbud_ff - 16'(w);
               bytes_in = bytes_ff - 25'(w);
               // flush the previous piece, hold this one until the end is known
               emit_pend = pendv_ff;
               pendv_in = 1'b1;
               if (w >= rdata_ff.len) begin
                  hn = (IDX_W+1)'(head_ff) + 1'b1;
                  head_in = (hn >= (IDX_W+1)'(QUEUE_DEPTH)) ?
                            IDX_W'(hn - (IDX_W+1)'(QUEUE_DEPTH)) : IDX_W'(hn);
                  count_in = count_ff - 1'b1;
                  cnt_in[CNT_SENT] = cnt_ff[CNT_SENT] + 32'd1;
                  nsent_in = nsent_ff + 1'b1;
                  st = ST_SENT_WHOLE;
                  state_in = (count_in != '0 && nsent_in < DEPTH_C) ? S_DR_RD : S_DR_END;
               end else begin
                  mem_we = 1'b1;
                  waddr = head_ff;
                  wdata = '{len: rdata_ff.len - w, prio: rdata_ff.prio,
                            drop: rdata_ff.drop};
                  st = ST_SENT_PART;
                  state_in = S_DR_END;
               end
               pend_in = '{status: st, evicted_count: '0, sent_bytes: w, last: 1'b0,
                           queued_count: 5'(count_in), held_bytes: bytes_in[23:0],
                           stat_value: '0, listener_up: listen_in};
            end
         end
         S_DR_END: begin
            emit_pend = 1'b1; pend_last = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            REG_ENABLED: begin
               en_in = csr_wdata[0];
               if (!csr_wdata[0]) begin
                  count_in = '0; bytes_in = '0; listen_in = 1'b0;
               end
            end
            REG_BUDGET: budget_in = (csr_wdata < 24'(BUDGET_FLOOR)) ?
                                    24'(BUDGET_FLOOR) : csr_wdata;
            REG_LIMIT: limit_in = (csr_wdata < 24'(BACKLOG_FLOOR)) ?
                                  24'(BACKLOG_FLOOR) : csr_wdata;
            default: ;
         endcase
      end

      rsp_in = rsp_ff;
      rspv_in = emit_new | emit_pend;
      if (emit_pend) begin
         rsp_in = pend_ff;
         rsp_in.last = pend_last;
      end else if (emit_new) begin
         rsp_in = '{status: st,
                    evicted_count: (st == ST_ACCEPTED || st == ST_NO_ROOM) ?
                                   5'(evict_in) : 5'd0,
                    sent_bytes: '0, last: 1'b1,
                    queued_count: 5'(count_in), held_bytes: bytes_in[23:0],
                    stat_value: statv, listener_up: listen_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         head_ff <= '0;
         bytes_ff <= '0;
         listen_ff <= 1'b0;
         en_ff <= 1'b0;
         budget_ff <= 24'(BUDGET_FLOOR);
         limit_ff <= 24'(BACKLOG_FLOOR);
         for (int k = 0; k < NUM_CNT; k++) begin
            cnt_ff[k] <= '0;
         end
         pubbytes_ff <= '0;
         rdv_ff <= 1'b0;
         pendv_ff <= 1'b0;
         rspv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         head_ff <= head_in;
         bytes_ff <= bytes_in;
         listen_ff <= listen_in;
         en_ff <= en_in;
         budget_ff <= budget_in;
         limit_ff <= limit_in;
         cnt_ff <= cnt_in;
         pubbytes_ff <= pubbytes_in;
         rdv_ff <= rdv_in;
         pendv_ff <= pendv_in;
         rspv_ff <= rspv_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      prio_ff <= prio_in;
      drop_ff <= drop_in;
      evict_ff <= evict_in;
      j_ff <= j_in;
      rdidx_ff <= rdidx_in;
      found_ff <= found_in;
      fidx_ff <= fidx_in;
      flen_ff <= flen_in;
      backlog_ff <= backlog_in;
      dbud_ff <= dbud_in;
      nsent_ff <= nsent_in;
      pend_ff <= pend_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rspv_ff;
   assign rsp_item = rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C) else $error("queue count above depth");
   a_empty_bytes: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> bytes_ff == '0) else $error("bytes left in empty queue");
   a_item_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid) else $error("accepted word dropped");
   a_accept_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == ST_ACCEPTED |-> rsp_item.queued_count != '0)
      else $error("accepted publish left queue empty");
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE && $past(state_ff) == S_IDLE && !$past(start) |-> !rsp_valid)
      else $error("word emitted without an item");

endmodule
